FILE: rtl/sccp_pkg.sv
// ----------------------------------------------------------------------------
// sccp_pkg
// Types and constants shared by the sector cache clock-policy engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sccp_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [2:0] KIND_HIT    = 3'd0;
  localparam logic [2:0] KIND_FILL   = 3'd1;
  localparam logic [2:0] KIND_EVICT  = 3'd2;
  localparam logic [2:0] KIND_FLUSH  = 3'd3;
  localparam logic [2:0] KIND_TICK   = 3'd4;
  localparam logic [2:0] KIND_PINNED = 3'd5;

  localparam logic REG_PINNED = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] sector;
    logic [31:0] owner_start;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  slot;
    logic [31:0] victim_sector;
    logic        writeback;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] pinned_owner;
    logic [3:0]  flush_period;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sector;
    logic [31:0] owner;
  } tag_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    tag_t              wdata;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

FILE: rtl/sector_cache_clock_policy_top.sv
// ----------------------------------------------------------------------------
// sector_cache_clock_policy_top
// Tag and clock (second-chance) replacement engine for a sector cache.
// ----------------------------------------------------------------------------
//   channel   handshake                payload
//   command   start / busy             item   (mode, sector, owner_start)
//   result    result_valid strobe      result (kind, slot, victim_sector,
//                                              writeback, last)
//   config    APB psel/penable/pready  pinned_owner @0x0, flush_period @0x4
//
// Flow: a read or write walks the valid tags at one per cycle through the
// tag RAM read port; a full-cache miss then sweeps the clock hand, at most
// two laps. A flushing tick scans the slots in order up to the last dirty
// one, or all 64 slots when none is dirty.
// Reset (rst, synchronous) clears flags, hand, tick and entry counts; the
// tag RAM needs no clearing since only filled slots are ever used.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_cache_clock_policy_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire sccp_pkg::item_t   item,
  output logic                   busy,
  output logic                   result_valid,
  output sccp_pkg::result_t      result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  sccp_pkg::cfg_t     cfg;
  sccp_pkg::ram_req_t req;
  sccp_pkg::tag_t     rdata;

  // hold the register values for the engine
  sccp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sector and owner tags, one registered read port
  sccp_tag_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // sequence lookup, fill, sweep and flush
  sccp_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .cfg          (cfg),
    .rdata        (rdata),
    .req          (req),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  // an ignored command produces no transfer
  a_none_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.mode == sccp_pkg::MODE_NONE |=> !result_valid)
    else $error("result after ignored command");

  // only flush transfers may be non-final
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != sccp_pkg::KIND_FLUSH |-> result.last)
    else $error("non-flush result without last");

  // the engine is idle once the final transfer shows
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("busy after final result");

endmodule

`default_nettype wire

FILE: rtl/sccp_tag_ram.sv
// ----------------------------------------------------------------------------
// sccp_tag_ram
// Tag store: sector and owner per slot, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sccp_tag_ram (
  input  wire logic              clk,
  input  wire sccp_pkg::ram_req_t req,
  output sccp_pkg::tag_t         rdata
);

  sccp_pkg::tag_t mem [sccp_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/sccp_cfg.sv
// ----------------------------------------------------------------------------
// sccp_cfg
// APB register file: pinned owner and flush period.
// ----------------------------------------------------------------------------
`default_nettype none

module sccp_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output sccp_pkg::cfg_t   cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pinned_owner <= 32'd0;
      cfg.flush_period <= 4'd4;
    end else if (wr) begin
      unique case (paddr[2])
        sccp_pkg::REG_PINNED: cfg.pinned_owner <= pwdata;
        sccp_pkg::REG_PERIOD: cfg.flush_period <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sccp_pkg::REG_PINNED: prdata = cfg.pinned_owner;
      sccp_pkg::REG_PERIOD: prdata = {28'd0, cfg.flush_period};
      default:              prdata = 32'd0;
    endcase
  end

  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule

`default_nettype wire

FILE: rtl/sccp_engine.sv
// ----------------------------------------------------------------------------
// sccp_engine
// Lookup, fill, clock sweep and flush sequencer around the tag store.
// ----------------------------------------------------------------------------
`default_nettype none

module sccp_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire sccp_pkg::item_t    item,
  input  wire sccp_pkg::cfg_t     cfg,
  input  wire sccp_pkg::tag_t     rdata,
  output sccp_pkg::ram_req_t      req,
  output logic                    busy,
  output logic                    result_valid,
  output sccp_pkg::result_t       result
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOKUP = 3'd1;
  localparam logic [2:0] ST_SW_RD  = 3'd2;
  localparam logic [2:0] ST_SW_CHK = 3'd3;
  localparam logic [2:0] ST_FL_SCN = 3'd4;
  localparam logic [2:0] ST_FL_OUT = 3'd5;

  localparam int CW = sccp_pkg::COUNT_W;
  localparam int SW = sccp_pkg::SLOT_W;
  localparam int N  = sccp_pkg::CAPACITY;

  logic [2:0]     state, state_next;
  logic [N-1:0]   valid, valid_next;
  logic [N-1:0]   accessed, accessed_next;
  logic [N-1:0]   dirty, dirty_next;
  logic [SW-1:0]  hand, hand_next;
  logic [3:0]     tick, tick_next;
  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  idx, idx_next;
  logic           pend, pend_next;
  logic [SW-1:0]  pidx, pidx_next;
  logic           any, any_next;
  logic           emitted, emitted_next;
  sccp_pkg::item_t cur, cur_next;
  logic           res_v_next;
  sccp_pkg::result_t res_next;

  logic [3:0]     tick_inc;
  logic [N-1:0]   higher;
  logic           wr_cur;

  assign busy     = (state != ST_IDLE);
  assign tick_inc = tick + 4'd1;
  assign wr_cur   = (cur.mode == sccp_pkg::MODE_WRITE);
  assign higher   = dirty & ({N{1'b1}} << idx[SW-1:0] << 1);

  always_comb begin
    state_next    = state;
    valid_next    = valid;
    accessed_next = accessed;
    dirty_next    = dirty;
    hand_next     = hand;
    tick_next     = tick;
    count_next    = count;
    idx_next      = idx;
    pend_next     = 1'b0;
    pidx_next     = pidx;
    any_next      = any;
    emitted_next  = emitted;
    cur_next      = cur;
    res_v_next    = 1'b0;
    res_next      = '0;
    res_next.last = 1'b1;
    req           = '0;
    req.wdata     = '{sector: cur.sector, owner: cur.owner_start};

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cur_next = item;
          idx_next = '0;
          any_next = 1'b0;
          emitted_next = 1'b0;
          case (item.mode) inside
            sccp_pkg::MODE_READ, sccp_pkg::MODE_WRITE: state_next = ST_LOOKUP;
            sccp_pkg::MODE_TICK: begin
              if (count == '0) begin
                res_v_next    = 1'b1;
                res_next.kind = sccp_pkg::KIND_TICK;
              end else if (tick_inc > cfg.flush_period) begin
                tick_next  = 4'd0;
                state_next = ST_FL_SCN;
              end else begin
                tick_next     = tick_inc;
                res_v_next    = 1'b1;
                res_next.kind = sccp_pkg::KIND_TICK;
              end
            end
            default: ;
          endcase
        end
      end

      ST_LOOKUP: begin
        // issue the next read while comparing the previous one
        req.raddr = idx[SW-1:0];
        if (idx < count) begin
          pend_next = 1'b1;
          pidx_next = idx[SW-1:0];
          idx_next  = idx + CW'(1);
        end
        if (pend) begin
          if (rdata.owner != cfg.pinned_owner) begin
            any_next = 1'b1;
          end
          if (rdata.sector == cur.sector) begin
            accessed_next[pidx] = 1'b1;
            if (wr_cur) begin
              dirty_next[pidx] = 1'b1;
            end
            res_v_next    = 1'b1;
            res_next.kind = sccp_pkg::KIND_HIT;
            res_next.slot = pidx;
            pend_next     = 1'b0;
            state_next    = ST_IDLE;
          end
        end else if (idx >= count) begin
          if (count < CW'(N)) begin
            req.we                       = 1'b1;
            req.waddr                    = count[SW-1:0];
            valid_next[count[SW-1:0]]    = 1'b1;
            accessed_next[count[SW-1:0]] = 1'b1;
            dirty_next[count[SW-1:0]]    = wr_cur;
            count_next                   = count + CW'(1);
            res_v_next                   = 1'b1;
            res_next.kind                = sccp_pkg::KIND_FILL;
            res_next.slot                = count[SW-1:0];
            state_next                   = ST_IDLE;
          end else if (!any) begin
            res_v_next    = 1'b1;
            res_next.kind = sccp_pkg::KIND_PINNED;
            res_next.slot = hand;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_SW_RD;
          end
        end
      end

      ST_SW_RD: begin
        req.raddr  = hand;
        state_next = ST_SW_CHK;
      end

      ST_SW_CHK: begin
        hand_next  = (hand == SW'(N - 1)) ? '0 : hand + SW'(1);
        state_next = ST_SW_RD;
        if (rdata.owner != cfg.pinned_owner) begin
          if (!accessed[hand]) begin
            req.we                 = 1'b1;
            req.waddr              = hand;
            accessed_next[hand]    = 1'b1;
            dirty_next[hand]       = wr_cur;
            res_v_next             = 1'b1;
            res_next.kind          = sccp_pkg::KIND_EVICT;
            res_next.slot          = hand;
            res_next.victim_sector = rdata.sector;
            res_next.writeback     = dirty[hand];
            state_next             = ST_IDLE;
          end else begin
            accessed_next[hand] = 1'b0;
          end
        end
      end

      ST_FL_SCN: begin
        req.raddr = idx[SW-1:0];
        if (idx == CW'(N)) begin
          if (!emitted) begin
            res_v_next    = 1'b1;
            res_next.kind = sccp_pkg::KIND_TICK;
          end
          state_next = ST_IDLE;
        end else if (dirty[idx[SW-1:0]]) begin
          state_next = ST_FL_OUT;
        end else begin
          idx_next = idx + CW'(1);
        end
      end

      ST_FL_OUT: begin
        dirty_next[idx[SW-1:0]] = 1'b0;
        emitted_next            = 1'b1;
        res_v_next              = 1'b1;
        res_next.kind           = sccp_pkg::KIND_FLUSH;
        res_next.slot           = idx[SW-1:0];
        res_next.victim_sector  = rdata.sector;
        res_next.writeback      = 1'b1;
        res_next.last           = (higher == '0);
        idx_next                = idx + CW'(1);
        state_next              = (higher == '0) ? ST_IDLE : ST_FL_SCN;
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      valid        <= '0;
      accessed     <= '0;
      dirty        <= '0;
      hand         <= '0;
      tick         <= '0;
      count        <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      valid        <= valid_next;
      accessed     <= accessed_next;
      dirty        <= dirty_next;
      hand         <= hand_next;
      tick         <= tick_next;
      count        <= count_next;
      pend         <= pend_next;
      result_valid <= res_v_next;
    end
    idx     <= idx_next;
    pidx    <= pidx_next;
    any     <= any_next;
    emitted <= emitted_next;
    cur     <= cur_next;
    result  <= res_next;
  end

  logic unused_valid;
  assign unused_valid = ^valid;

endmodule

`default_nettype wire

FILE: verif/tb_sector_cache_clock_policy_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_cache_clock_policy_top
// Drives sector accesses and timer ticks into the cache engine while an
// internal copy of the tag store and clock hand predicts every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sector_cache_clock_policy_top;

  logic              clk;
  logic              rst;
  logic              start;
  sccp_pkg::item_t   item;
  logic              busy;
  logic              result_valid;
  sccp_pkg::result_t result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  sector_cache_clock_policy_top dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the tag store and policy state.
  logic        sh_valid    [sccp_pkg::CAPACITY];
  logic [31:0] sh_sector   [sccp_pkg::CAPACITY];
  logic [31:0] sh_owner    [sccp_pkg::CAPACITY];
  logic        sh_accessed [sccp_pkg::CAPACITY];
  logic        sh_dirty    [sccp_pkg::CAPACITY];
  logic [5:0]  sh_hand;
  logic [3:0]  sh_ticks;
  int          sh_count;
  logic [31:0] sh_pinned;
  logic [3:0]  sh_period;

  sccp_pkg::item_t   pending_cmds[$];
  sccp_pkg::result_t expected_results[$];
  int      errors;

  // Fresh sectors from a small pool so hits are frequent.
  logic [31:0] sector_pool[16];
  logic [31:0] owner_pool[4];

  function automatic sccp_pkg::result_t mk(logic [2:0] k, int s, logic [31:0] v,
                                           logic wb, logic l);
    sccp_pkg::result_t r;
    r.kind = k;
    r.slot = s[5:0];
    r.victim_sector = v;
    r.writeback = wb;
    r.last = l;
    return r;
  endfunction

  function automatic void cache_fill(int s, sccp_pkg::item_t it);
    sh_valid[s]    = 1'b1;
    sh_sector[s]   = it.sector;
    sh_owner[s]    = it.owner_start;
    sh_accessed[s] = 1'b1;
    sh_dirty[s]    = (it.mode == sccp_pkg::MODE_WRITE);
  endfunction

  // Advance the shadow state by one command and queue what it produces.
  function automatic void predict_access(sccp_pkg::item_t it);
    int n;
    int s;
    bit any;
    if (it.mode == sccp_pkg::MODE_NONE) return;
    if (it.mode == sccp_pkg::MODE_TICK) begin
      n = 0;
      if (sh_count == 0) begin
        expected_results.push_back(mk(sccp_pkg::KIND_TICK, 0, 0, 0, 1));
        return;
      end
      sh_ticks = sh_ticks + 4'd1;
      if (sh_ticks > sh_period) begin
        for (int i = 0; i < sccp_pkg::CAPACITY; i++) begin
          if (sh_valid[i] && sh_dirty[i]) begin
            expected_results.push_back(mk(sccp_pkg::KIND_FLUSH, i, sh_sector[i], 1, 0));
            sh_dirty[i] = 1'b0;
            n++;
          end
        end
        sh_ticks = 4'd0;
      end
      if (n == 0) expected_results.push_back(mk(sccp_pkg::KIND_TICK, 0, 0, 0, 1));
      else expected_results[$].last = 1'b1;
      return;
    end
    for (int i = 0; i < sccp_pkg::CAPACITY; i++) begin
      if (sh_valid[i] && sh_sector[i] == it.sector) begin
        sh_accessed[i] = 1'b1;
        if (it.mode == sccp_pkg::MODE_WRITE) sh_dirty[i] = 1'b1;
        expected_results.push_back(mk(sccp_pkg::KIND_HIT, i, 0, 0, 1));
        return;
      end
    end
    if (sh_count < sccp_pkg::CAPACITY) begin
      for (int i = 0; i < sccp_pkg::CAPACITY; i++) begin
        if (!sh_valid[i]) begin
          cache_fill(i, it);
          sh_count++;
          expected_results.push_back(mk(sccp_pkg::KIND_FILL, i, 0, 0, 1));
          return;
        end
      end
    end
    any = 0;
    for (int i = 0; i < sccp_pkg::CAPACITY; i++)
      if (sh_valid[i] && sh_owner[i] != sh_pinned) any = 1;
    if (any) begin
      for (int k = 0; k < 2 * sccp_pkg::CAPACITY + 1; k++) begin
        s = int'(sh_hand);
        sh_hand = sh_hand + 6'd1;
        if (!sh_valid[s] || sh_owner[s] == sh_pinned) continue;
        if (!sh_accessed[s]) begin
          expected_results.push_back(mk(sccp_pkg::KIND_EVICT, s, sh_sector[s],
                                        sh_dirty[s], 1));
          cache_fill(s, it);
          return;
        end
        sh_accessed[s] = 1'b0;
      end
    end
    expected_results.push_back(mk(sccp_pkg::KIND_PINNED, int'(sh_hand), 0, 0, 1));
  endfunction

  // Clock.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Limit: generous fixed time.
  initial begin
    #20ms;
    $display("[sector_cache_clock_policy_top] ERROR");
    $finish;
  end

  // Driver: hold start until the transfer is taken, idle at random.
  bit quiet;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_access(item);
        void'(pending_cmds.pop_front());
      end
      if ((start && !busy) || !start) begin
        if (pending_cmds.size() > 0 && (quiet || $urandom_range(99) >= 15)) begin
          start <= 1'b1;
          item  <= pending_cmds[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result %p", $realtime, result);
        errors++;
      end else if (expected_results[0] != result) begin
        $display("%0t mismatch: expected %p actual %p", $realtime,
                 expected_results[0], result);
        errors++;
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  // Wait until all queued commands are taken and results have drained.
  task automatic drain();
    while (pending_cmds.size() != 0 || start || busy || expected_results.size() != 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Register write: setup then access; pready is tied high.
  task automatic reg_write(logic addr_sel, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= (addr_sel == sccp_pkg::REG_PERIOD) ? 3'd4 : 3'd0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr_sel == sccp_pkg::REG_PERIOD) sh_period = v[3:0];
    else sh_pinned = v;
  endtask

  function automatic sccp_pkg::item_t cmd(logic [1:0] m, logic [31:0] s,
                                          logic [31:0] o);
    sccp_pkg::item_t it;
    it.mode = m;
    it.sector = s;
    it.owner_start = o;
    return it;
  endfunction

  // Mostly accesses drawn from small pools, some wide random values.
  function automatic sccp_pkg::item_t rand_cmd();
    int r;
    logic [1:0] m;
    r = $urandom_range(99);
    m = (r < 45) ? sccp_pkg::MODE_READ :
        (r < 80) ? sccp_pkg::MODE_WRITE :
        (r < 95) ? sccp_pkg::MODE_TICK : sccp_pkg::MODE_NONE;
    if ($urandom_range(9) < 7)
      return cmd(m, sector_pool[$urandom_range(15)], owner_pool[$urandom_range(3)]);
    return cmd(m, $urandom, $urandom);
  endfunction

  initial begin
    rst = 1; start = 0; item = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    errors = 0; quiet = 0;
    for (int i = 0; i < sccp_pkg::CAPACITY; i++) begin
      sh_valid[i] = 0; sh_sector[i] = 0; sh_owner[i] = 0;
      sh_accessed[i] = 0; sh_dirty[i] = 0;
    end
    sh_hand = 0; sh_ticks = 0; sh_count = 0; sh_pinned = 0; sh_period = 4;
    for (int i = 0; i < 16; i++) sector_pool[i] = $urandom;
    sector_pool[0] = 32'h0; sector_pool[1] = 32'hFFFF_FFFF;
    owner_pool[0] = 32'h0; owner_pool[1] = 32'hFFFF_FFFF;
    owner_pool[2] = $urandom; owner_pool[3] = 32'h5555_AAAA;
    repeat (7) @(posedge clk);
    rst <= 0;

    // Directed: tick on empty cache, ignored mode, extremes, hits, writes.
    reg_write(sccp_pkg::REG_PINNED, 32'hFFFF_FFFF);
    reg_write(sccp_pkg::REG_PERIOD, 32'd0);
    pending_cmds.push_back(cmd(sccp_pkg::MODE_TICK, 0, 0));
    pending_cmds.push_back(cmd(sccp_pkg::MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(cmd(sccp_pkg::MODE_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(cmd(sccp_pkg::MODE_READ, 32'h0, 32'hFFFF_FFFF));
    pending_cmds.push_back(cmd(sccp_pkg::MODE_READ, 32'hFFFF_FFFF, 32'h0));
    pending_cmds.push_back(cmd(sccp_pkg::MODE_WRITE, 32'h0, 32'h1));
    pending_cmds.push_back(cmd(sccp_pkg::MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(cmd(sccp_pkg::MODE_TICK, 0, 0));
    drain();

    // Fill the cache with pinned entries only: misses find no victim.
    for (int i = 2; i < sccp_pkg::CAPACITY; i++)
      pending_cmds.push_back(cmd(sccp_pkg::MODE_WRITE, 32'h1000 + i, 32'hFFFF_FFFF));
    drain();
    reg_write(sccp_pkg::REG_PINNED, 32'hFFFF_FFFF);
    pending_cmds.push_back(cmd(sccp_pkg::MODE_READ, 32'h7777, 32'h3));
    pending_cmds.push_back(cmd(sccp_pkg::MODE_TICK, 0, 0));
    drain();

    // Unpin: sweeps clear accessed marks, then evict without writeback.
    reg_write(sccp_pkg::REG_PINNED, 32'h0000_0000);
    for (int i = 0; i < 4; i++)
      pending_cmds.push_back(cmd(sccp_pkg::MODE_READ, 32'h2000 + i, 32'h0));
    drain();

    // Random phases across register settings, including the extremes.
    for (int p = 0; p < 5; p++) begin
      reg_write(sccp_pkg::REG_PERIOD, (p == 4) ? 32'd15 : $urandom_range(0, 6));
      reg_write(sccp_pkg::REG_PINNED,
                (p == 1) ? 32'hFFFF_FFFF : owner_pool[$urandom_range(3)]);
      quiet = (p == 2);
      for (int i = 0; i < 15; i++) pending_cmds.push_back(rand_cmd());
      drain();
    end

    if (errors == 0) begin
      $display("[sector_cache_clock_policy_top] OK");
    end else begin
      $display("[sector_cache_clock_policy_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
